@@ design/crcxm_pkg.sv @@
package crcxm_pkg;

    // Field widths fixed by the interface
    localparam int SIZE_WIDTH = 24;
    localparam int DATA_WIDTH = 8;
    localparam int CRC_WIDTH  = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Defaults for the top-level parameters
    localparam int BLOCK_BYTES_DEF = 128;
    localparam int COUNT_WIDTH_DEF = 24;

    // Padding bytes
    localparam logic [DATA_WIDTH-1:0] CTRL_Z_BYTE = 8'h1A;
    localparam logic [DATA_WIDTH-1:0] ERASED_BYTE = 8'hFF;

    // Configuration register map (word index)
    localparam logic REG_IMAGE_SIZE = 1'b0;
    localparam logic [SIZE_WIDTH-1:0] IMAGE_SIZE_RESET = 24'd49152;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data_byte;
        logic                  byte_valid;
        logic                  is_last;
    } in_item_t;

    typedef struct packed {
        logic [CRC_WIDTH-1:0] crc_value;
        logic                 overflow;
    } out_item_t;

    // One byte of CRC-16/XMODEM (poly 0x1021), shift-and-xor form
    function automatic logic [CRC_WIDTH-1:0] crc_byte(
        input logic [CRC_WIDTH-1:0]  crc,
        input logic [DATA_WIDTH-1:0] b
    );
        logic [CRC_WIDTH-1:0] c;
        c = {crc[7:0], crc[15:8]};
        c[7:0] = c[7:0] ^ b;
        c = c ^ {12'b0, c[7:4]};
        c = c ^ {c[3:0], 12'b0};
        c = c ^ {3'b0, c[7:0], 5'b0};
        return c;
    endfunction

endpackage

@@ design/crc16_xmodem_padded_image_core.sv @@
// Data items: one per cycle, no result; the CRC unit folds the byte in at acceptance.
// Last item: the result shows once R padding bytes are folded in, R = padding count
// (image_size - data bytes, or 0 on overflow); before that come a compare, a reciprocal
// multiply and a remainder step, then the single CRC byte unit takes one padding byte per cycle.
// Input is stalled from the last item until its result is loaded into the output register,
// so the next item waits for the padding run and the result load, longer if out_stall holds.
// Reset clears the running CRC, byte count and flags, and sets image_size to 49152.
module crc16_xmodem_padded_image_core #(
    parameter int BLOCK_BYTES = crcxm_pkg::BLOCK_BYTES_DEF,
    parameter int COUNT_WIDTH = crcxm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  crcxm_pkg::in_item_t                  in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output crcxm_pkg::out_item_t                 out_item,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [crcxm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [crcxm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [crcxm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import crcxm_pkg::*;

    localparam int CMP_W   = (COUNT_WIDTH > SIZE_WIDTH) ? COUNT_WIDTH : SIZE_WIDTH;
    localparam int REM_W   = $clog2(BLOCK_BYTES + 1);
    localparam int BLK_LOG = $clog2(BLOCK_BYTES);
    localparam int SHIFT_W = SIZE_WIDTH + BLK_LOG;
    localparam int PROD_W  = SHIFT_W + SIZE_WIDTH + 1;

    // Rounded-up reciprocal of the block size, exact for any SIZE_WIDTH-bit dividend
    localparam logic [63:0] MAGIC_FULL =
        ((64'd1 << SHIFT_W) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
    localparam logic [SIZE_WIDTH:0] MAGIC = MAGIC_FULL[SIZE_WIDTH:0];

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_PAD  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [CRC_WIDTH-1:0]   crc_reg, crc_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   ovf_seen_reg, ovf_seen_next;
    logic                   ovf_reg, ovf_next;
    logic [SIZE_WIDTH-1:0]  pad_cnt_reg, pad_cnt_next;
    logic [SIZE_WIDTH-1:0]  div_reg, div_next;
    logic [SIZE_WIDTH-1:0]  quot_reg, quot_next;
    logic [REM_W-1:0]       cz_reg, cz_next;
    logic                   res_valid_reg, res_valid_next;
    out_item_t              res_reg, res_next;
    logic [SIZE_WIDTH-1:0]  image_size_reg;

    logic                   in_accept;
    logic                   out_take;
    logic                   cfg_write;
    logic [DATA_WIDTH-1:0]  unit_byte;
    logic [CRC_WIDTH-1:0]   unit_crc;
    logic [CMP_W-1:0]       count_ext;
    logic [CMP_W-1:0]       size_ext;
    logic [CMP_W-1:0]       diff;
    logic                   calc_ovf;
    logic [PROD_W-1:0]      recip_prod;
    logic [SIZE_WIDTH-1:0]  back_prod;
    logic [SIZE_WIDTH-1:0]  mod_full;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = res_valid_reg && !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_IMAGE_SIZE);
    assign prdata    = (paddr[2] == REG_IMAGE_SIZE)
                     ? {{(APB_DATA_W-SIZE_WIDTH){1'b0}}, image_size_reg}
                     : '0;

    // Shared CRC byte unit: file data when idle, padding bytes otherwise
    assign unit_byte = (state_reg == ST_IDLE) ? in_item.data_byte
                     : ((cz_reg != '0) ? CTRL_Z_BYTE : ERASED_BYTE);
    assign unit_crc  = crc_byte(crc_reg, unit_byte);

    // Remaining-byte compare and subtract
    assign count_ext = CMP_W'(count_reg);
    assign size_ext  = CMP_W'(image_size_reg);
    assign diff      = size_ext - count_ext;
    assign calc_ovf  = ovf_seen_reg || (count_ext > size_ext);

    // Quotient by reciprocal multiply, remainder by multiply back and subtract
    assign recip_prod = PROD_W'(div_reg) * PROD_W'(MAGIC);
    assign back_prod  = quot_reg * SIZE_WIDTH'(BLOCK_BYTES);
    assign mod_full   = div_reg - back_prod;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        crc_next       = crc_reg;
        count_next     = count_reg;
        ovf_seen_next  = ovf_seen_reg;
        ovf_next       = ovf_reg;
        pad_cnt_next   = pad_cnt_reg;
        div_next       = div_reg;
        quot_next      = quot_reg;
        cz_next        = cz_reg;
        res_valid_next = res_valid_reg && !out_take;
        res_next       = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Fold in data, count it, saturate the counter
                if (in_accept)
                begin
                    if (in_item.byte_valid)
                    begin
                        crc_next = unit_crc;
                        if (count_reg == {COUNT_WIDTH{1'b1}})
                            ovf_seen_next = 1'b1;
                        else
                            count_next = count_reg + 1'b1;
                    end
                    if (in_item.is_last)
                        state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                // Work out the padding length
                ovf_next     = calc_ovf;
                pad_cnt_next = calc_ovf ? '0 : diff[SIZE_WIDTH-1:0];
                div_next     = calc_ovf ? '0 : diff[SIZE_WIDTH-1:0];
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                // Hold the number of whole blocks
                quot_next  = recip_prod[SHIFT_W +: SIZE_WIDTH];
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                // Ctrl-Z run is what is left over the whole blocks
                cz_next    = mod_full[REM_W-1:0];
                state_next = ST_PAD;
            end
            ST_PAD:
            begin
                // Feed Ctrl-Z bytes first, then erased bytes
                if (pad_cnt_reg != '0)
                begin
                    crc_next     = unit_crc;
                    pad_cnt_next = pad_cnt_reg - 1'b1;
                    if (cz_reg != '0)
                        cz_next = cz_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Load the result once the output register is free, then clear
                if (!res_valid_reg || out_take)
                begin
                    res_valid_next     = 1'b1;
                    res_next.crc_value = crc_reg;
                    res_next.overflow  = ovf_reg;
                    crc_next           = '0;
                    count_next         = '0;
                    ovf_seen_next      = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            crc_reg        <= '0;
            count_reg      <= '0;
            ovf_seen_reg   <= 1'b0;
            ovf_reg        <= 1'b0;
            pad_cnt_reg    <= '0;
            cz_reg         <= '0;
            res_valid_reg  <= 1'b0;
            image_size_reg <= IMAGE_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            ovf_seen_reg  <= ovf_seen_next;
            ovf_reg       <= ovf_next;
            pad_cnt_reg   <= pad_cnt_next;
            cz_reg        <= cz_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write)
                image_size_reg <= pwdata[SIZE_WIDTH-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        quot_reg <= quot_next;
        res_reg  <= res_next;
    end

    // Padding count only moves down
    a_pad_down: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |=> (pad_cnt_reg <= $past(pad_cnt_reg)))
        else $error("padding count increased");

    // Ctrl-Z run never outlasts the padding
    a_cz_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |-> (cz_reg <= REM_W'(pad_cnt_reg) || pad_cnt_reg > cz_reg))
        else $error("Ctrl-Z count exceeds padding count");

    // Ctrl-Z run stays below the block size
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |-> ((REM_W+1)'(cz_reg) < (REM_W+1)'(BLOCK_BYTES)))
        else $error("remainder out of range");

    // Overflowed images get no padding
    a_ovf_nopad: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD && ovf_reg) |-> (pad_cnt_reg == '0))
        else $error("padding on overflowed image");

    // A new result only comes from the done step
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside done step");

endmodule

@@ sim/crc16_xmodem_padded_image_core_tb.sv @@
`timescale 1ns / 100ps

module crc16_xmodem_padded_image_core_tb;

    import crcxm_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int BLOCK_BYTES    = BLOCK_BYTES_DEF;
    localparam int COUNT_WIDTH    = COUNT_WIDTH_DEF;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int MAX_GAP        = 13;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 250000;
    localparam int N_DIRECTED     = 21;
    localparam int MAX_REPORTS    = 10;

    localparam logic [CRC_WIDTH-1:0]   CRC_POLY  = 16'h1021;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [APB_ADDR_W-1:0]  IMAGE_SIZE_ADDR =
        APB_ADDR_W'(4 * int'(REG_IMAGE_SIZE));

    // Directed table columns
    localparam logic KEEP  = 1'b0;
    localparam logic RESIZE = 1'b1;
    localparam logic PRED  = 1'b0;
    localparam logic FIXED = 1'b1;

    typedef struct packed {
        logic                  reconf;
        logic [SIZE_WIDTH-1:0] size;
        in_item_t              item;
        logic                  typed;
        out_item_t             want;
    } dir_row_t;

    // reconf, size, {data, valid, last}, typed, {crc, overflow}
    dir_row_t directed_rows [N_DIRECTED] = '{
        {KEEP,   24'd0,      {8'h00, 1'b0, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h00, 1'b1, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'hFF, 1'b1, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h5C, 1'b0, 1'b1}, PRED,  {16'h0000, 1'b0}},
        {RESIZE, 24'd0,      {8'hFF, 1'b0, 1'b1}, FIXED, {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h00, 1'b1, 1'b1}, FIXED, {16'h0000, 1'b1}},
        {KEEP,   24'd0,      {8'hA5, 1'b1, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h5A, 1'b1, 1'b1}, PRED,  {16'h0000, 1'b0}},
        {RESIZE, 24'd5,      {8'h01, 1'b1, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h02, 1'b1, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h04, 1'b0, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h08, 1'b1, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h10, 1'b1, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h20, 1'b1, 1'b1}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h80, 1'b1, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h40, 1'b1, 1'b1}, PRED,  {16'h0000, 1'b0}},
        {RESIZE, 24'd200,    {8'h20, 1'b1, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'hC3, 1'b0, 1'b1}, PRED,  {16'h0000, 1'b0}},
        {RESIZE, 24'hFFFFFF, {8'h7E, 1'b1, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {KEEP,   24'd0,      {8'h3C, 1'b1, 1'b0}, PRED,  {16'h0000, 1'b0}},
        {RESIZE, 24'd130,    {8'hE7, 1'b1, 1'b1}, PRED,  {16'h0000, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the image CRC state and the size register
    logic [CRC_WIDTH-1:0]   image_crc = '0;
    logic [COUNT_WIDTH-1:0] image_bytes = '0;
    logic                   image_sat = 1'b0;
    logic [SIZE_WIDTH-1:0]  size_shadow = IMAGE_SIZE_RESET;

    out_item_t crc_results_due [$];

    bit in_burst = 1'b0;
    bit out_burst = 1'b0;

    int mismatches = 0;
    int items_sent = 0;
    int data_sent = 0;
    int images_checked = 0;
    int overflow_images = 0;
    int size_writes = 0;
    int longest_pad = 0;
    int quiet_cycles = 0;

    crc16_xmodem_padded_image_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #(CLK_HALF) clk = ~clk;

    // Bit-serial CRC-16, MSB first
    function automatic logic [CRC_WIDTH-1:0] crc_shift(
        input logic [CRC_WIDTH-1:0]  crc,
        input logic [DATA_WIDTH-1:0] b
    );
        logic fb;
        for (int i = DATA_WIDTH - 1; i >= 0; i--)
        begin
            fb = crc[CRC_WIDTH-1] ^ b[i];
            crc = {crc[CRC_WIDTH-2:0], 1'b0};
            if (fb)
                crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    // Fold one item into the shadow state; return 1 when it closes an image
    function automatic bit absorb_item(input in_item_t it, output out_item_t res);
        logic                  ovf;
        logic [SIZE_WIDTH-1:0] pad;
        int                    ctrlz;
        res = '0;
        if (it.byte_valid)
        begin
            image_crc = crc_shift(image_crc, it.data_byte);
            if (image_bytes == COUNT_MAX)
                image_sat = 1'b1;
            else
                image_bytes = image_bytes + 1'b1;
        end
        if (!it.is_last)
            return 1'b0;
        // Pad with Ctrl-Z up to a block boundary, then erased flash
        ovf = image_sat || (image_bytes > size_shadow);
        pad = ovf ? '0 : size_shadow - image_bytes;
        ctrlz = int'(pad) % BLOCK_BYTES;
        repeat (ctrlz) image_crc = crc_shift(image_crc, CTRL_Z_BYTE);
        repeat (int'(pad) - ctrlz) image_crc = crc_shift(image_crc, ERASED_BYTE);
        if (int'(pad) > longest_pad)
            longest_pad = int'(pad);
        res.crc_value = image_crc;
        res.overflow = ovf;
        image_crc = '0;
        image_bytes = '0;
        image_sat = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [SIZE_WIDTH-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll <= 6)
            return SIZE_WIDTH'($urandom_range(1, 64));
        if (roll <= 8)
            return SIZE_WIDTH'($urandom_range(65, 700));
        return SIZE_WIDTH'($urandom_range(701, 3000));
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s expected %h got %h", what, want, got);
    endtask

    task automatic apb_write(input logic [APB_DATA_W-1:0] word);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= IMAGE_SIZE_ADDR;
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(output logic [APB_DATA_W-1:0] word);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= IMAGE_SIZE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        word = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and wait until every pending image has come out
    task automatic quiesce();
        in_valid <= 1'b0;
        while (crc_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reconfigure(input logic [SIZE_WIDTH-1:0] size);
        logic [APB_DATA_W-1:0] word;
        logic [APB_DATA_W-1:0] got;
        quiesce();
        // Upper bits are junk; only the low 24 land in the register
        word = $urandom;
        word[SIZE_WIDTH-1:0] = size;
        apb_write(word);
        size_shadow = size;
        size_writes++;
        apb_read(got);
        if (got[SIZE_WIDTH-1:0] !== size)
            flag_mismatch("image_size readback", 32'(size), 32'(got[SIZE_WIDTH-1:0]));
    endtask

    // Present one item, after a random gap unless in a burst, and hold it until accepted
    task automatic drive_item(input in_item_t it, input logic typed, input out_item_t want);
        int        gap;
        bit        done;
        out_item_t res;
        gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (it.byte_valid || it.is_last)
            items_sent++;
        if (it.byte_valid)
            data_sent++;
        done = absorb_item(it, res);
        if (done)
            crc_results_due.push_back(typed ? want : res);
    endtask

    task automatic send_image(input int len, input bit resize_midway);
        in_item_t it;
        for (int k = 0; k < len; k++)
        begin
            // Occasional empty item in the middle of the data
            if ($urandom_range(0, 9) == 0)
            begin
                it = {8'($urandom), 1'b0, 1'b0};
                drive_item(it, PRED, '0);
            end
            if (resize_midway && k == len / 2)
                reconfigure(pick_size());
            it = {8'($urandom), 1'b1, 1'b0};
            drive_item(it, PRED, '0);
        end
        it = {8'($urandom), 1'($urandom), 1'b1};
        drive_item(it, PRED, '0);
    endtask

    // Result side: stall at random before taking each item, with no stall in a burst
    initial
    begin : result_sink
        int hold;
        forever
        begin
            hold = out_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest pending image
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (crc_results_due.size() == 0)
                flag_mismatch("result with no image pending", 32'h0, 32'(out_item));
            else
            begin
                want = crc_results_due.pop_front();
                images_checked++;
                if (want.overflow)
                    overflow_images++;
                if (out_item.crc_value !== want.crc_value)
                    flag_mismatch("crc_value", 32'(want.crc_value), 32'(out_item.crc_value));
                if (out_item.overflow !== want.overflow)
                    flag_mismatch("overflow", 32'(want.overflow), 32'(out_item.overflow));
            end
        end
    end

    // Watchdog: end the run after a long stretch with no handshake
    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) || psel))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("crc16_xmodem_padded_image_core_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [APB_DATA_W-1:0] got;
        dir_row_t              row;
        int                    images;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register comes up at its reset value
        apb_read(got);
        if (got[SIZE_WIDTH-1:0] !== IMAGE_SIZE_RESET)
            flag_mismatch("image_size after reset", 32'(IMAGE_SIZE_RESET),
                          32'(got[SIZE_WIDTH-1:0]));

        // Directed table
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            row = directed_rows[r];
            if (row.reconf)
                reconfigure(row.size);
            drive_item(row.item, row.typed, row.want);
        end

        // Random phases: a new size in most phases, one to four images, idling style per phase
        while (items_sent < N_DIRECTED + RANDOM_ITEMS)
        begin
            in_burst = ($urandom_range(0, 4) == 0);
            out_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) != 0)
                reconfigure(pick_size());
            images = $urandom_range(1, 4);
            repeat (images)
                send_image($urandom_range(0, 40), $urandom_range(0, 15) == 0);
        end

        // Drain
        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (crc_results_due.size() != 0)
            flag_mismatch("images never completed", 32'h0, 32'(crc_results_due.size()));

        $display("%0d items sent (%0d data bytes), %0d images checked, %0d with overflow",
                 items_sent, data_sent, images_checked, overflow_images);
        $display("%0d image_size writes, longest padding run %0d bytes, %0d mismatches",
                 size_writes, longest_pad, mismatches);
        if (mismatches == 0)
            $display("crc16_xmodem_padded_image_core_tb OK");
        else
            $display("crc16_xmodem_padded_image_core_tb NOT OK");
        $finish;
    end

endmodule

@@ crc16_xmodem_padded_image_core.f @@
design/crcxm_pkg.sv
design/crc16_xmodem_padded_image_core.sv
sim/crc16_xmodem_padded_image_core_tb.sv
